FILE: design/cclp_pkg.sv
// Shared types and status codes for the CSS color literal parser.
// No dependencies; used by the parse core, the top level and the checker.
package cclp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic        color_valid;
    logic [31:0] color_word;
    logic [3:0]  parse_status;
  } out_beat_t;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_TOO_SHORT   = 4'd1;
  localparam logic [3:0] ST_BAD_HEX     = 4'd2;
  localparam logic [3:0] ST_BAD_HEX_LEN = 4'd3;
  localparam logic [3:0] ST_UNPARSED    = 4'd4;
  localparam logic [3:0] ST_TOO_MANY    = 4'd5;
  localparam logic [3:0] ST_TOO_FEW     = 4'd6;
  localparam logic [3:0] ST_INCOMPLETE  = 4'd7;
  localparam logic [3:0] ST_NOT_RECOG   = 4'd8;

endpackage

FILE: design/cclp_parse_core.sv
// Per-character parse state and next-state logic for the color parser.
// Depends on cclp_pkg; builds the result beat for the final character.
module cclp_parse_core #(
  parameter int FRACTION_DIGITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  cclp_pkg::in_beat_t beat,
  output cclp_pkg::out_beat_t result
);

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  localparam longint unsigned DEN   = pow10(FRACTION_DIGITS);
  localparam int              NW    = $clog2(255 * DEN);
  localparam int              SH    = NW + $clog2(DEN);
  localparam int              PW    = SH + 8;
  localparam longint unsigned RECIP = ((64'd1 << SH) + DEN - 64'd1) / DEN;
  localparam int              FCW   = $clog2(FRACTION_DIGITS + 1);

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_A     = 8'h61;

  typedef enum logic [6:0] {
    PH_START  = 7'b0000001,
    PH_HEX    = 7'b0000010,
    PH_PREFIX = 7'b0000100,
    PH_NUM    = 7'b0001000,
    PH_PCT    = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_NAMED  = 7'b1000000
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [2:0]      pfx_r, pfx_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [23:0]     hex_r, hex_nxt;
  logic            afm_r, afm_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [7:0]      comp_r [3];
  logic [7:0]      comp_nxt [3];
  logic [7:0]      alpha_r, alpha_nxt;
  logic [15:0]     whole_r, whole_nxt;
  logic [NW-1:0]   fracw_r, fracw_nxt;
  logic [FCW-1:0]  fcnt_r, fcnt_nxt;
  logic            dseen_r, dseen_nxt;
  logic            pseen_r, pseen_nxt;
  logic [3:0]      stat_r, stat_nxt;

  logic [NW-1:0]   weight_tab [FRACTION_DIGITS + 1];
  logic [PW-1:0]   prod;
  logic [7:0]      alpha_val;
  logic [7:0]      comp_val;
  logic [1:0]      last_idx;
  logic [7:0]      c;
  logic            is_digit;
  logic            hex_ok;
  logic [3:0]      hex_nib;
  logic [19:0]     wsum;
  logic            run_num;
  logic            do_sep;
  logic            clear_num;
  logic            fin;
  logic [3:0]      fin_st;
  logic [3:0]      st;
  logic            cvalid;
  logic [31:0]     cword;

  for (genvar k = 0; k <= FRACTION_DIGITS; k++) begin : g_weight
    if (k < FRACTION_DIGITS) begin : g_w
      assign weight_tab[k] = NW'(64'd255 * pow10(FRACTION_DIGITS - 1 - k));
    end else begin : g_z
      assign weight_tab[k] = '0;
    end
  end

  assign c        = beat.char_code;
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign last_idx = afm_r ? 2'd3 : 2'd2;
  assign prod      = PW'(fracw_r) * PW'(RECIP);
  assign alpha_val = (whole_r != 16'd0) ? 8'hFF : prod[SH +: 8];
  assign comp_val  = (whole_r > 16'd255) ? 8'hFF : whole_r[7:0];

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = c[3:0];
    if (is_digit) begin
      hex_nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_nib = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pfx_nxt   = pfx_r;
    cnt_nxt   = (cnt_r != 4'hF) ? cnt_r + 4'd1 : cnt_r;
    hex_nxt   = hex_r;
    afm_nxt   = afm_r;
    idx_nxt   = idx_r;
    comp_nxt  = comp_r;
    alpha_nxt = alpha_r;
    whole_nxt = whole_r;
    fracw_nxt = fracw_r;
    fcnt_nxt  = fcnt_r;
    dseen_nxt = dseen_r;
    pseen_nxt = pseen_r;
    stat_nxt  = stat_r;
    run_num   = 1'b0;
    do_sep    = 1'b0;
    clear_num = 1'b0;
    fin       = 1'b0;
    fin_st    = cclp_pkg::ST_OK;
    wsum      = '0;

    unique case (phase_r)
      PH_START: begin
        if (c == CH_HASH) begin
          phase_nxt = PH_HEX;
        end else if (c == CH_R) begin
          phase_nxt = PH_PREFIX;
          pfx_nxt   = 3'd1;
        end else begin
          phase_nxt = PH_NAMED;
        end
      end
      PH_HEX: begin
        if (cnt_r <= 4'd6) begin
          if (hex_ok) hex_nxt = {hex_r[19:0], hex_nib};
          else stat_nxt = cclp_pkg::ST_BAD_HEX;
        end
      end
      PH_PREFIX: begin
        pfx_nxt = pfx_r + 3'd1;
        case (pfx_r)
          3'd1: if (c != CH_G) phase_nxt = PH_NAMED;
          3'd2: if (c != CH_B) phase_nxt = PH_NAMED;
          3'd3: begin
            afm_nxt = (c == CH_A);
            if (c != CH_A) begin
              idx_nxt   = 2'd0;
              clear_num = 1'b1;
              phase_nxt = PH_NUM;
            end
          end
          default: begin
            idx_nxt   = 2'd0;
            clear_num = 1'b1;
            phase_nxt = PH_NUM;
          end
        endcase
      end
      PH_NUM: run_num = 1'b1;
      PH_PCT: begin
        if (c == CH_COMMA || c == CH_RPAR) begin
          do_sep = 1'b1;
        end else if (idx_r >= last_idx) begin
          fin    = 1'b1;
          fin_st = cclp_pkg::ST_UNPARSED;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          clear_num = 1'b1;
          phase_nxt = PH_NUM;
          run_num   = 1'b1;
        end
      end
      default: ;
    endcase

    if (clear_num) begin
      whole_nxt = '0;
      fracw_nxt = '0;
      fcnt_nxt  = '0;
      dseen_nxt = 1'b0;
      pseen_nxt = 1'b0;
    end

    if (run_num) begin
      if (c == CH_MINUS) begin
        fin    = 1'b1;
        fin_st = cclp_pkg::ST_UNPARSED;
      end else if (c == CH_DOT) begin
        if (pseen_nxt) begin
          fin    = 1'b1;
          fin_st = cclp_pkg::ST_UNPARSED;
        end else begin
          pseen_nxt = 1'b1;
        end
      end else if (is_digit) begin
        if (!pseen_nxt) begin
          wsum      = 20'(whole_nxt) * 20'd10 + 20'(c[3:0]);
          whole_nxt = (wsum > 20'd65535) ? 16'hFFFF : wsum[15:0];
        end else begin
          fracw_nxt = fracw_nxt + NW'(weight_tab[fcnt_nxt] * c[3:0]);
          if (fcnt_nxt != FCW'(FRACTION_DIGITS)) fcnt_nxt = fcnt_nxt + FCW'(1);
        end
        dseen_nxt = 1'b1;
      end else if (!dseen_nxt) begin
        fin    = 1'b1;
        fin_st = cclp_pkg::ST_UNPARSED;
      end else begin
        if (idx_r != 2'd3) comp_nxt[idx_r] = comp_val;
        else alpha_nxt = alpha_val;
        if (c == CH_PCT) begin
          phase_nxt = PH_PCT;
        end else if (c == CH_COMMA || c == CH_RPAR) begin
          do_sep = 1'b1;
        end else begin
          fin    = 1'b1;
          fin_st = cclp_pkg::ST_UNPARSED;
        end
      end
    end

    if (do_sep) begin
      if (c == CH_COMMA) begin
        if (idx_r >= last_idx) begin
          fin    = 1'b1;
          fin_st = cclp_pkg::ST_TOO_MANY;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          whole_nxt = '0;
          fracw_nxt = '0;
          fcnt_nxt  = '0;
          dseen_nxt = 1'b0;
          pseen_nxt = 1'b0;
          phase_nxt = PH_NUM;
        end
      end else begin
        fin    = 1'b1;
        fin_st = (idx_r < last_idx) ? cclp_pkg::ST_TOO_FEW : cclp_pkg::ST_OK;
      end
    end

    if (fin) begin
      stat_nxt  = fin_st;
      phase_nxt = PH_DONE;
    end
  end

  always_comb begin
    st     = cclp_pkg::ST_INCOMPLETE;
    cvalid = 1'b0;
    cword  = '0;
    if (cnt_nxt < 4'd2) begin
      st = cclp_pkg::ST_TOO_SHORT;
    end else if (phase_nxt == PH_HEX) begin
      if (cnt_nxt == 4'd4 || cnt_nxt == 4'd7) begin
        if (stat_nxt == cclp_pkg::ST_BAD_HEX) begin
          st = cclp_pkg::ST_BAD_HEX;
        end else begin
          st     = cclp_pkg::ST_OK;
          cvalid = 1'b1;
          if (cnt_nxt == 4'd4) begin
            cword = {8'hFF, hex_nxt[3:0], hex_nxt[3:0], hex_nxt[7:4], hex_nxt[7:4],
                     hex_nxt[11:8], hex_nxt[11:8]};
          end else begin
            cword = {8'hFF, hex_nxt[7:0], hex_nxt[15:8], hex_nxt[23:16]};
          end
        end
      end else begin
        st = cclp_pkg::ST_BAD_HEX_LEN;
      end
    end else if (phase_nxt == PH_NAMED || phase_nxt == PH_START || cnt_nxt <= 4'd5) begin
      st = cclp_pkg::ST_NOT_RECOG;
    end else if (phase_nxt == PH_DONE) begin
      st = stat_nxt;
      if (stat_nxt == cclp_pkg::ST_OK) begin
        cvalid = 1'b1;
        cword  = {(afm_nxt ? alpha_nxt : 8'hFF), comp_nxt[2], comp_nxt[1], comp_nxt[0]};
      end
    end else if (phase_nxt == PH_NUM) begin
      st = dseen_nxt ? cclp_pkg::ST_INCOMPLETE : cclp_pkg::ST_UNPARSED;
    end
  end

  assign result.color_valid  = cvalid;
  assign result.color_word   = cword;
  assign result.parse_status = st;

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && beat.last_char)) begin
      phase_r <= PH_START;
      pfx_r   <= '0;
      cnt_r   <= '0;
      hex_r   <= '0;
      afm_r   <= 1'b0;
      idx_r   <= '0;
      comp_r  <= '{default: 8'h00};
      alpha_r <= 8'hFF;
      whole_r <= '0;
      fracw_r <= '0;
      fcnt_r  <= '0;
      dseen_r <= 1'b0;
      pseen_r <= 1'b0;
      stat_r  <= cclp_pkg::ST_OK;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pfx_r   <= pfx_nxt;
      cnt_r   <= cnt_nxt;
      hex_r   <= hex_nxt;
      afm_r   <= afm_nxt;
      idx_r   <= idx_nxt;
      comp_r  <= comp_nxt;
      alpha_r <= alpha_nxt;
      whole_r <= whole_nxt;
      fracw_r <= fracw_nxt;
      fcnt_r  <= fcnt_nxt;
      dseen_r <= dseen_nxt;
      pseen_r <= pseen_nxt;
      stat_r  <= stat_nxt;
    end
  end

endmodule

FILE: design/css_color_literal_parser.sv
// Top level of the CSS color literal parser: input register, parse core, result register.
// Depends on cclp_pkg and cclp_parse_core.
//
// The block takes one character per clock when not stalled and gives one result beat per
// string, on the character flagged last_char. Each character is registered in the input
// register, where the parse core updates its state; the result is formed from it and
// loaded into the output register when the final character leaves the input register.
// The only stall comes from the output register: a final character waits in
// the input register while the previous result is still unclaimed on the out_ channel.
// FRACTION_DIGITS sets how many fraction digits of a number are kept.
module css_color_literal_parser #(
  parameter int FRACTION_DIGITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cclp_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cclp_pkg::out_beat_t out_data
);

  cclp_pkg::in_beat_t  in_r;
  logic                in_v_r;
  cclp_pkg::out_beat_t out_r;
  logic                out_v_r;
  cclp_pkg::out_beat_t res;
  logic                out_free;
  logic                go;

  assign out_free = !out_v_r || out_ready;
  assign go       = in_v_r && (!in_r.last_char || out_free);
  assign in_ready = !in_v_r || go;

  cclp_parse_core #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(go),
    .beat   (in_r),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go && in_r.last_char) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && in_r.last_char) out_r <= res;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

FILE: design/cclp_checker.sv
// Port-level checks on the result channel of the color parser.
// Depends on cclp_pkg; bound to css_color_literal_parser below.
module cclp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input cclp_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.color_valid |-> out_data.parse_status == cclp_pkg::ST_OK)
    else $error("color flagged valid with error status");

  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.color_valid |-> out_data.color_word == 32'd0)
    else $error("nonzero color word on failed parse");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.parse_status <= cclp_pkg::ST_NOT_RECOG)
    else $error("status code out of range");

endmodule

bind css_color_literal_parser cclp_checker u_cclp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

FILE: tb/cclp_checker.sv
// Scoreboard for the CSS color literal parser: predicts one result per string from the
// accepted character beats and compares each result beat against it, field by field.
// Depends on cclp_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps

module cclp_scoreboard #(
  parameter int FRAC_KEEP = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  cclp_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  cclp_pkg::out_beat_t out_data,
  output int                  mismatches,
  output int                  due,
  output int                  strings_done,
  output int                  colors_ok,
  output logic [15:0]         codes_seen
);

  typedef enum logic [2:0] {
    AT_START, IN_HASH, IN_KEYWORD, IN_VALUE, PAST_PCT, DECIDED, UNKNOWN_WORD
  } scan_t;

  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_R     = "r";
  localparam logic [7:0] CH_G     = "g";
  localparam logic [7:0] CH_B     = "b";
  localparam logic [7:0] CH_A     = "a";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_POINT = ".";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_CLOSE = ")";
  localparam logic [7:0] CH_PCT   = "%";

  scan_t       ph;
  logic [2:0]  kw_pos;
  logic [3:0]  seen_len;
  logic [23:0] hex_acc;
  logic        is_rgba;
  logic [1:0]  field_no;
  logic [7:0]  field_val [3];
  logic [7:0]  alpha_val;
  logic [15:0] int_acc;
  int unsigned frac_acc;
  int unsigned frac_len;
  logic        have_digit;
  logic        have_point;
  logic [3:0]  held_code;

  cclp_pkg::out_beat_t colors_due [$];
  int        bad;
  int        compared;
  int        decoded;
  logic [15:0] code_hits;

  function automatic void queue_result(input cclp_pkg::out_beat_t r);
    colors_due = {colors_due, r};
  endfunction

  function automatic void clear_value();
    int_acc    = '0;
    frac_acc   = 0;
    frac_len   = 0;
    have_digit = 1'b0;
    have_point = 1'b0;
  endfunction

  function automatic void restart_scan();
    ph        = AT_START;
    kw_pos    = '0;
    seen_len  = '0;
    hex_acc   = '0;
    is_rgba   = 1'b0;
    field_no  = '0;
    field_val[0] = '0;
    field_val[1] = '0;
    field_val[2] = '0;
    alpha_val = 8'hFF;
    held_code = cclp_pkg::ST_OK;
    clear_value();
  endfunction

  function automatic void settle(input logic [3:0] code);
    held_code = code;
    ph        = DECIDED;
  endfunction

  function automatic logic [1:0] top_field();
    return is_rgba ? 2'd3 : 2'd2;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] alpha_from_value();
    longint unsigned pow10;
    longint unsigned prod;
    pow10 = 1;
    if (int_acc != 0) return 8'hFF;
    for (int i = 0; i < frac_len; i++) pow10 = pow10 * 10;
    prod = (longint'(frac_acc) * 255) / pow10;
    return (prod > 255) ? 8'hFF : prod[7:0];
  endfunction

  function automatic void store_field();
    if (field_no < 3) field_val[field_no] = (int_acc > 255) ? 8'hFF : int_acc[7:0];
    else alpha_val = alpha_from_value();
  endfunction

  function automatic void advance_field();
    field_no = field_no + 2'd1;
    clear_value();
    ph = IN_VALUE;
  endfunction

  function automatic void separator(input logic [7:0] c);
    if (c == CH_COMMA) begin
      if (field_no >= top_field()) settle(cclp_pkg::ST_TOO_MANY);
      else advance_field();
    end else begin
      if (field_no < top_field()) settle(cclp_pkg::ST_TOO_FEW);
      else settle(cclp_pkg::ST_OK);
    end
  endfunction

  function automatic void value_char(input logic [7:0] c);
    int unsigned d;
    int unsigned w;
    if (c == CH_MINUS) begin
      settle(cclp_pkg::ST_UNPARSED);
    end else if (c == CH_POINT) begin
      if (have_point) settle(cclp_pkg::ST_UNPARSED);
      else have_point = 1'b1;
    end else if (c >= "0" && c <= "9") begin
      d = c - "0";
      if (!have_point) begin
        w = int_acc * 10 + d;
        int_acc = (w > 65535) ? 16'hFFFF : w[15:0];
      end else if (frac_len < FRAC_KEEP) begin
        frac_acc = frac_acc * 10 + d;
        frac_len = frac_len + 1;
      end
      have_digit = 1'b1;
    end else if (!have_digit) begin
      settle(cclp_pkg::ST_UNPARSED);
    end else begin
      store_field();
      if (c == CH_PCT) ph = PAST_PCT;
      else if (c == CH_COMMA || c == CH_CLOSE) separator(c);
      else settle(cclp_pkg::ST_UNPARSED);
    end
  endfunction

  function automatic void after_pct(input logic [7:0] c);
    if (c == CH_COMMA || c == CH_CLOSE) begin
      separator(c);
    end else if (field_no >= top_field()) begin
      settle(cclp_pkg::ST_UNPARSED);
    end else begin
      advance_field();
      value_char(c);
    end
  endfunction

  task automatic parse_char(input cclp_pkg::in_beat_t b);
    logic [7:0] c;
    logic [3:0] pos;
    int         nib;
    logic [7:0] r, g, bl, a;
    cclp_pkg::out_beat_t res;
    c   = b.char_code;
    pos = seen_len;
    if (seen_len < 15) seen_len = seen_len + 4'd1;
    case (ph)
      AT_START: begin
        if (c == CH_HASH) begin
          ph = IN_HASH;
        end else if (c == CH_R) begin
          ph     = IN_KEYWORD;
          kw_pos = 3'd1;
        end else begin
          ph = UNKNOWN_WORD;
        end
      end
      IN_HASH: begin
        if (pos <= 6) begin
          nib = hex_digit(c);
          if (nib < 0) held_code = cclp_pkg::ST_BAD_HEX;
          else hex_acc = {hex_acc[19:0], nib[3:0]};
        end
      end
      IN_KEYWORD: begin
        case (kw_pos)
          3'd1: if (c != CH_G) ph = UNKNOWN_WORD;
          3'd2: if (c != CH_B) ph = UNKNOWN_WORD;
          3'd3: begin
            is_rgba = (c == CH_A);
            if (!is_rgba) begin
              field_no = '0;
              clear_value();
              ph = IN_VALUE;
            end
          end
          default: begin
            field_no = '0;
            clear_value();
            ph = IN_VALUE;
          end
        endcase
        kw_pos = kw_pos + 3'd1;
      end
      IN_VALUE: value_char(c);
      PAST_PCT: after_pct(c);
      default: ;
    endcase

    if (b.last_char) begin
      res = '0;
      if (seen_len < 2) begin
        res.parse_status = cclp_pkg::ST_TOO_SHORT;
      end else if (ph == IN_HASH) begin
        if (seen_len == 4 || seen_len == 7) begin
          if (held_code == cclp_pkg::ST_BAD_HEX) begin
            res.parse_status = cclp_pkg::ST_BAD_HEX;
          end else begin
            if (seen_len == 4) begin
              r  = {2{hex_acc[11:8]}};
              g  = {2{hex_acc[7:4]}};
              bl = {2{hex_acc[3:0]}};
            end else begin
              r  = hex_acc[23:16];
              g  = hex_acc[15:8];
              bl = hex_acc[7:0];
            end
            res.color_valid  = 1'b1;
            res.parse_status = cclp_pkg::ST_OK;
            res.color_word   = {8'hFF, bl, g, r};
          end
        end else begin
          res.parse_status = cclp_pkg::ST_BAD_HEX_LEN;
        end
      end else if (ph == UNKNOWN_WORD || ph == AT_START || seen_len <= 5) begin
        res.parse_status = cclp_pkg::ST_NOT_RECOG;
      end else if (ph == DECIDED) begin
        res.parse_status = held_code;
        if (held_code == cclp_pkg::ST_OK) begin
          a = is_rgba ? alpha_val : 8'hFF;
          res.color_valid = 1'b1;
          res.color_word  = {a, field_val[2], field_val[1], field_val[0]};
        end
      end else if (ph == IN_VALUE) begin
        res.parse_status = have_digit ? cclp_pkg::ST_INCOMPLETE : cclp_pkg::ST_UNPARSED;
      end else begin
        res.parse_status = cclp_pkg::ST_INCOMPLETE;
      end
      queue_result(res);
      restart_scan();
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    bad++;
  endtask

  task automatic check_color(input cclp_pkg::out_beat_t got);
    cclp_pkg::out_beat_t want;
    if (colors_due.size() == 0) begin
      report("result beat with no string pending", {27'b0, got.color_valid, got.parse_status},
             32'b0);
    end else begin
      want = colors_due.pop_front();
      if (got.color_valid !== want.color_valid)
        report("color_valid", 32'(got.color_valid), 32'(want.color_valid));
      if (got.color_word !== want.color_word)
        report("color_word", got.color_word, want.color_word);
      if (got.parse_status !== want.parse_status)
        report("parse_status", 32'(got.parse_status), 32'(want.parse_status));
      compared++;
      if (want.color_valid) decoded++;
      code_hits[want.parse_status] = 1'b1;
    end
  endtask

  initial begin
    bad       = 0;
    compared  = 0;
    decoded   = 0;
    code_hits = '0;
    restart_scan();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_scan();
      colors_due.delete();
    end else begin
      if (out_valid && out_ready) check_color(out_data);
      if (in_valid && in_ready) parse_char(in_data);
    end
    mismatches   <= bad;
    due          <= colors_due.size();
    strings_done <= compared;
    colors_ok    <= decoded;
    codes_seen   <= code_hits;
  end

endmodule

FILE: tb/tb_top.sv
// Top of the CSS color literal parser testbench: clock, reset, string stimulus with
// random gaps on both channels, watchdog and verdict. Depends on cclp_pkg, the block
// and cclp_scoreboard, which predicts and compares the result beats.
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC_KEEP   = 4;
  localparam int CHAR_TARGET = 1800;
  localparam int STALL_LIMIT = 2000;

  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_OPEN  = "(";
  localparam logic [7:0] CH_CLOSE = ")";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_POINT = ".";
  localparam logic [7:0] CH_PCT   = "%";

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  cclp_pkg::in_beat_t  in_data   = '0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  cclp_pkg::out_beat_t out_data;

  int          mismatches;
  int          due;
  int          strings_done;
  int          colors_ok;
  logic [15:0] codes_seen;

  bit          calm = 1'b0;
  int          chars_sent = 0;
  int          strings_sent = 0;
  int          quiet = 0;
  logic [7:0]  line_buf [$];

  always #1 clk = ~clk;

  css_color_literal_parser #(.FRACTION_DIGITS(FRAC_KEEP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  cclp_scoreboard #(.FRAC_KEEP(FRAC_KEEP)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .due          (due),
    .strings_done (strings_done),
    .colors_ok    (colors_ok),
    .codes_seen   (codes_seen)
  );

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [7:0] odd_char();
    string pool;
    pool = "-.,)%0959 x(";
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  task automatic push_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.char_code <= c;
    in_data.last_char <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) push_char(line_buf[i], i == line_buf.size() - 1);
    strings_sent++;
  endtask

  task automatic add_char(input logic [7:0] c);
    line_buf = {line_buf, c};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    add_text(s);
    send_line();
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (due != 0);
  endtask

  task automatic add_value(input bit is_alpha);
    int v;
    int k;
    case ($urandom_range(7))
      0:       v = $urandom_range(9);
      1, 2, 3: v = $urandom_range(255);
      4:       v = $urandom_range(300, 240);
      5:       v = $urandom_range(99999);
      default: v = $urandom_range(1);
    endcase
    if (is_alpha && $urandom_range(2) != 0) v = 0;
    if ($urandom_range(7) != 0) add_text($sformatf("%0d", v));
    if ((is_alpha && $urandom_range(3) != 0) || $urandom_range(3) == 0) begin
      add_char(CH_POINT);
      k = $urandom_range(6);
      for (int i = 0; i < k; i++) add_char(8'("0" + $urandom_range(9)));
    end
    if ($urandom_range(5) == 0) add_char(CH_PCT);
  endtask

  task automatic build_func_color();
    bit four;
    int parts;
    int keep;
    four = $urandom_range(1);
    add_text(four ? "rgba" : "rgb");
    add_char(($urandom_range(7) == 0) ? odd_char() : CH_OPEN);
    parts = four ? 4 : 3;
    if ($urandom_range(9) == 0) parts = $urandom_range(1) ? parts + 1 : parts - 1;
    for (int i = 0; i < parts; i++) begin
      add_value(four && i == 3);
      add_char((i == parts - 1) ? CH_CLOSE : CH_COMMA);
    end
    if ($urandom_range(6) == 0)
      line_buf[$urandom_range(line_buf.size() - 1, 3)] = odd_char();
    if ($urandom_range(9) == 0) begin
      keep = $urandom_range(line_buf.size() - 1, 1);
      while (line_buf.size() > keep) void'(line_buf.pop_back());
    end
    if ($urandom_range(11) == 0) add_text("x9)");
  endtask

  task automatic build_hex_color();
    string digits;
    int    n;
    digits = "0123456789abcdefABCDEF";
    n = ($urandom_range(4) == 0) ? $urandom_range(8) : ($urandom_range(1) ? 3 : 6);
    add_char(CH_HASH);
    for (int i = 0; i < n; i++) add_char(digits[$urandom_range(21)]);
    if (n > 0 && $urandom_range(9) == 0) line_buf[$urandom_range(n, 1)] = odd_char();
  endtask

  task automatic build_noise();
    int n;
    case ($urandom_range(5))
      0: add_text("r");
      1: add_text("rg");
      2: add_text("rgc");
      default: ;
    endcase
    n = $urandom_range(6, line_buf.size() == 0 ? 1 : 0);
    for (int i = 0; i < n; i++) add_char(8'($urandom_range(255)));
  endtask

  initial begin
    int gap;
    wait (rst_n);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles, %0d results pending", quiet, due);
      $display("css_color_literal_parser verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    string directed [] = '{
      "a", "#fA0", "#00ff7F", "#12g", "#12345", "rgb(255,0,128)", "rgba(10,20,30,0.5)",
      "rgb(-1,2,3)", "rgb(1.2.3,4,5)", "rgb(,1,2)", "rgb(1;2,3)", "rgb(1,2,3,4)",
      "rgb(1,2)", "rgb(50%,20%30%)", "rgb(1,2,3%x", "rgb(99999,3.99,256)",
      "rgba(0,0,0,0.123456)", "rgba(0,0,0,2)", "rgb(1,2,3", "rgb(1,2,", "rgb(1%",
      "red", "rgb()", "rgbX7,8,9)junk", "rgba(100,200,150,.25)"
    };
    int kind;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_text(directed[i]);
    line_buf = '{CH_HASH, 8'hFF, 8'h00, 8'h7F};
    send_line();
    line_buf = '{8'h00, 8'hFF};
    send_line();
    hold_until_drained();

    while (chars_sent < CHAR_TARGET) begin
      if (strings_sent % 25 == 0) calm = ~calm;
      line_buf.delete();
      kind = $urandom_range(9);
      if (kind < 6) build_func_color();
      else if (kind < 9) build_hex_color();
      else build_noise();
      send_line();
      if ($urandom_range(29) == 0) hold_until_drained();
    end
    calm = 1'b0;

    hold_until_drained();
    repeat (16) @(posedge clk);

    $display("Covered %0d strings in %0d character beats; %0d results checked, %0d colors.",
             strings_sent, chars_sent, strings_done, colors_ok);
    $display("Status codes seen (bit per code): %b", codes_seen[8:0]);
    if (due != 0) $display("%0d expected results never arrived", due);
    if (mismatches == 0 && due == 0) begin
      $display("css_color_literal_parser verification clean");
    end else begin
      $display("css_color_literal_parser verification failed");
    end
    $finish;
  end

endmodule
